FILE: hdl/spectral_sharpen_dehalo_gain_macros.svh
// ----------------------------------------------------------------------------
// spectral sharpen / dehalo gain assertion macros
// shared concurrent assertion forms, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_SHARPEN_DEHALO_GAIN_MACROS_SVH
`define SPECTRAL_SHARPEN_DEHALO_GAIN_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SSDG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssdg assertion failed");
// next-cycle implication
`define SSDG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssdg assertion failed");
`else
`define SSDG_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSDG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/ssdg_pkg.sv
// ----------------------------------------------------------------------------
// ssdg_pkg
// constants and types of the spectral sharpen / dehalo gain block
// ----------------------------------------------------------------------------
package ssdg_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS       = 30;   // sharpen ratio fraction bits
  localparam int T_BITS          = 16;   // dehalo ratio fraction bits
  localparam int DQ_BITS         = 13;   // dehalo gain quotient bits
  localparam int SQ_STEPS        = 17;   // square root steps over 33 bits
  localparam int CFG_BITS        = 48;
  localparam logic [15:0] ONE_Q12 = 16'd4096;

  typedef enum logic [2:0] {
    REG_SHARPEN_AMOUNT    = 3'd0,
    REG_SHARPEN_SIGMA_MAX = 3'd1,
    REG_SHARPEN_SIGMA_MIN = 3'd2,
    REG_DEHALO_AMOUNT     = 3'd3,
    REG_DEHALO_THRESHOLD  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] sa;
    logic [47:0]        smax;
    logic [47:0]        smin;
    logic [15:0]        da;
    logic [47:0]        dh;
  } cfg_t;

endpackage

FILE: hdl/spectral_sharpen_dehalo_gain.sv
// ----------------------------------------------------------------------------
// spectral_sharpen_dehalo_gain
// per-bin sharpen and dehalo spectral gain with degrid subtraction
// ----------------------------------------------------------------------------
// One complex bin is taken per clock whenever bin_stall is low. The latency
// is set by the three bit-serial ratio dividers (30 stages), followed by the
// 17-stage square root that runs next to the 13-stage dehalo gain divider.
// Empty stages collapse, so a stalled output only holds the input back once
// every stage holds a word. Configuration is read live and must be written
// while no word is in flight.
module spectral_sharpen_dehalo_gain #(
  parameter int SAMPLE_BITS = ssdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [ssdg_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          bin_valid,
  output logic                          bin_stall,
  input  logic signed [SAMPLE_BITS-1:0] bin_real,
  input  logic signed [SAMPLE_BITS-1:0] bin_imag,
  input  logic signed [SAMPLE_BITS-1:0] grid_real,
  input  logic signed [SAMPLE_BITS-1:0] grid_imag,
  input  logic [15:0]                   sharpen_weight,
  input  logic [15:0]                   dehalo_weight,
  input  logic signed [23:0]            grid_fraction,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [SAMPLE_BITS-1:0] out_real,
  output logic signed [SAMPLE_BITS-1:0] out_imag
);

  `include "spectral_sharpen_dehalo_gain_macros.svh"

  localparam int SB  = SAMPLE_BITS;
  localparam int FW  = SB + 24;
  localparam int GW  = SB + 8;
  localparam int DW  = (SB + 9 > 33) ? SB + 9 : 33;
  localparam int OW  = (GW + 2 > 37) ? GW + 2 : 37;
  localparam int FB  = ssdg_pkg::FRAC_BITS;
  localparam int TB  = ssdg_pkg::T_BITS;
  localparam int QB  = ssdg_pkg::DQ_BITS;
  localparam int NSQ = ssdg_pkg::SQ_STEPS;

  localparam int ST_GC   = 1;
  localparam int ST_C    = 2;
  localparam int ST_SQ   = 3;
  localparam int ST_P    = 4;
  localparam int ST_DEN  = 5;
  localparam int ST_DIV0 = 6;
  localparam int ST_R    = ST_DIV0 + FB;
  localparam int ST_RT0  = ST_R + 1;
  localparam int ST_DD0  = ST_R + 1;
  localparam int ST_WV   = ST_RT0 + NSQ;
  localparam int ST_SP   = ST_WV + 1;
  localparam int ST_S    = ST_SP + 1;
  localparam int ST_G1   = ST_S + 1;
  localparam int ST_G    = ST_G1 + 1;
  localparam int ST_O1   = ST_G + 1;
  localparam int ST_O    = ST_O1 + 1;
  localparam int NST     = ST_O + 1;

  localparam logic signed [DW-1:0] C_MAX = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] C_MIN = DW'(-64'sd2147483648);
  localparam logic signed [OW-1:0] O_MAX = OW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] O_MIN = OW'(-(64'sd1 <<< (SB - 1)));

  typedef struct packed {
    logic                 byp;
    logic signed [SB-1:0] br;
    logic signed [SB-1:0] bi;
    logic signed [SB-1:0] gr;
    logic signed [SB-1:0] gi;
    logic [15:0]          ws;
    logic [15:0]          wd;
    logic signed [23:0]   f;
    logic signed [GW-1:0] gcr;
    logic signed [GW-1:0] gci;
    logic signed [31:0]   cr;
    logic signed [31:0]   ci;
    logic [63:0]          sqr;
    logic [63:0]          sqi;
    logic [63:0]          p;
    logic [63:0]          r1;
    logic [63:0]          d1;
    logic [FB:0]          q1;
    logic                 s1;
    logic [63:0]          r2;
    logic [63:0]          d2;
    logic [FB:0]          q2;
    logic                 s2;
    logic [63:0]          r3;
    logic [63:0]          d3;
    logic [TB:0]          q3;
    logic                 s3;
    logic [15:0]          dw;
    logic [FB:0]          rr;
    logic [33:0]          den;
    logic [40:0]          dnum;
    logic [QB-1:0]        dq;
    logic [32:0]          sv;
    logic [34:0]          sres;
    logic [32:0]          wv;
    logic signed [49:0]   sp;
    logic signed [15:0]   sg;
    logic [QB-1:0]        dg;
    logic signed [29:0]   gp;
    logic signed [15:0]   g;
    logic signed [47:0]   pr;
    logic signed [47:0]   pi;
    logic signed [SB-1:0] outr;
    logic signed [SB-1:0] outi;
  } pipe_t;

  ssdg_pkg::cfg_t cfg;
  pipe_t          pipe [NST];
  pipe_t          in_word;
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // one restoring step of n*2^k/d: remainder doubles, subtract when it reaches d
  function automatic logic [64:0] div_step(input logic [63:0] r, input logic [63:0] d);
    logic [64:0] tw;
    begin
      tw = {r, 1'b0};
      if (tw >= {1'b0, d}) begin
        div_step = {1'b1, 64'(tw - {1'b0, d})};
      end else begin
        div_step = {1'b0, tw[63:0]};
      end
    end
  endfunction

  function automatic logic signed [SB-1:0] sat_out(input logic signed [47:0] pr,
                                                    input logic signed [GW-1:0] gc);
    logic signed [47:0]   tmp;
    logic signed [OW-1:0] o;
    begin
      tmp = pr + 48'sd2048;
      o = OW'(tmp >>> 12) + OW'(gc);
      if (o > O_MAX) begin
        sat_out = SB'(O_MAX);
      end else if (o < O_MIN) begin
        sat_out = SB'(O_MIN);
      end else begin
        sat_out = SB'(o);
      end
    end
  endfunction

  function automatic pipe_t step(input int k, input pipe_t x, input ssdg_pkg::cfg_t c);
    pipe_t                y;
    logic signed [FW-1:0] mr;
    logic signed [FW-1:0] mi;
    logic signed [DW-1:0] dr;
    logic signed [DW-1:0] di;
    logic signed [63:0]   sq;
    logic [64:0]          ds;
    logic [61:0]          qq;
    logic [32:0]          dt;
    logic [34:0]          sbit;
    logic [34:0]          vin;
    logic [34:0]          rin;
    logic [46:0]          dsh;
    logic signed [50:0]   rp;
    logic signed [18:0]   rs;
    logic signed [31:0]   rg;
    int                   i;
    begin
      y = x;
      if (k == ST_GC) begin
        mr = FW'(x.f) * FW'(x.gr) + (FW'(1) <<< 15);
        mi = FW'(x.f) * FW'(x.gi) + (FW'(1) <<< 15);
        y.gcr = GW'(mr >>> 16);
        y.gci = GW'(mi >>> 16);
      end
      if (k == ST_C) begin
        dr = DW'(x.br) - DW'(x.gcr);
        di = DW'(x.bi) - DW'(x.gci);
        y.cr = (dr > C_MAX) ? 32'(C_MAX) : ((dr < C_MIN) ? 32'(C_MIN) : 32'(dr));
        y.ci = (di > C_MAX) ? 32'(C_MAX) : ((di < C_MIN) ? 32'(C_MIN) : 32'(di));
      end
      if (k == ST_SQ) begin
        sq = x.cr * x.cr;
        y.sqr = sq;
        sq = x.ci * x.ci;
        y.sqi = sq;
      end
      if (k == ST_P) begin
        y.p = x.sqr + x.sqi + 64'd1;
      end
      if (k == ST_DEN) begin
        y.d1 = x.p + 64'(c.smin);
        y.d2 = x.p + 64'(c.smax);
        y.d3 = x.p + 64'(c.dh);
        y.r1 = x.p;
        y.r2 = 64'(c.smax);
        y.r3 = x.p;
        y.s1 = (x.p >= y.d1);
        y.s2 = (64'(c.smax) >= y.d2);
        y.s3 = (x.p >= y.d3);
        y.q1 = y.s1 ? ((FB + 1)'(1) << FB) : '0;
        y.q2 = y.s2 ? ((FB + 1)'(1) << FB) : '0;
        y.q3 = y.s3 ? ((TB + 1)'(1) << TB) : '0;
        y.dw = 16'((32'(c.da) * 32'(x.wd) + 32'h8000) >> 16);
      end
      if (k >= ST_DIV0 && k < ST_DIV0 + FB) begin
        if (!x.s1) begin
          ds = div_step(x.r1, x.d1);
          y.r1 = ds[63:0];
          y.q1 = {x.q1[FB-1:0], ds[64]};
        end
        if (!x.s2) begin
          ds = div_step(x.r2, x.d2);
          y.r2 = ds[63:0];
          y.q2 = {x.q2[FB-1:0], ds[64]};
        end
        if (!x.s3 && k < ST_DIV0 + TB) begin
          ds = div_step(x.r3, x.d3);
          y.r3 = ds[63:0];
          y.q3 = {x.q3[TB-1:0], ds[64]};
        end
      end
      if (k == ST_R) begin
        qq = 62'(x.q1) * 62'(x.q2);
        y.rr = (FB + 1)'(qq >> FB);
        dt = 33'(x.dw) * 33'(x.q3);
        y.den = (34'd1 << 28) + 34'(dt);
        y.dnum = (41'd1 << 40) + 41'(y.den >> 1);
        y.dq = '0;
      end
      // square root, two bits of the radicand per stage
      if (k >= ST_RT0 && k < ST_RT0 + NSQ) begin
        sbit = 35'd1 << (2 * (NSQ - 1 - (k - ST_RT0)));
        vin = (k == ST_RT0) ? {2'b00, x.rr, 2'b00} : 35'(x.sv);
        rin = (k == ST_RT0) ? '0 : x.sres;
        if (vin >= rin + sbit) begin
          y.sv = 33'(vin - (rin + sbit));
          y.sres = (rin >> 1) + sbit;
        end else begin
          y.sv = 33'(vin);
          y.sres = rin >> 1;
        end
      end
      // dehalo gain quotient, most significant bit first
      if (k >= ST_DD0 && k < ST_DD0 + QB) begin
        i = QB - 1 - (k - ST_DD0);
        dsh = 47'(x.den) << i;
        if (47'(x.dnum) >= dsh) begin
          y.dnum = 41'(47'(x.dnum) - dsh);
          y.dq = x.dq | (QB'(1) << i);
        end
      end
      if (k == ST_WV) begin
        y.wv = 33'(x.ws) * 33'(x.sres[16:0]);
      end
      if (k == ST_SP) begin
        y.sp = 50'(c.sa) * $signed({17'd0, x.wv});
      end
      if (k == ST_S) begin
        rp = 51'(x.sp) + (51'sd1 <<< 31);
        rs = 19'(rp >>> 32) + 19'sd4096;
        if (c.sa == 16'sd0) begin
          y.sg = $signed(ssdg_pkg::ONE_Q12);
        end else if (rs > 19'sd32767) begin
          y.sg = 16'sh7fff;
        end else if (rs < -19'sd32768) begin
          y.sg = 16'sh8000;
        end else begin
          y.sg = 16'(rs);
        end
        y.dg = (c.da == 16'd0) ? QB'(ssdg_pkg::ONE_Q12) : x.dq;
      end
      if (k == ST_G1) begin
        y.gp = 30'(x.sg) * $signed({17'd0, x.dg});
      end
      if (k == ST_G) begin
        rg = (32'(x.gp) + 32'sd2048) >>> 12;
        if (rg > 32'sd32767) begin
          y.g = 16'sh7fff;
        end else if (rg < -32'sd32768) begin
          y.g = 16'sh8000;
        end else begin
          y.g = 16'(rg);
        end
      end
      if (k == ST_O1) begin
        y.pr = 48'(x.cr) * 48'(x.g);
        y.pi = 48'(x.ci) * 48'(x.g);
      end
      if (k == ST_O) begin
        y.outr = x.byp ? x.br : sat_out(x.pr, x.gcr);
        y.outi = x.byp ? x.bi : sat_out(x.pi, x.gci);
      end
      step = y;
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ssdg_pkg::REG_SHARPEN_AMOUNT:    cfg.sa   <= cfg_data[15:0];
        ssdg_pkg::REG_SHARPEN_SIGMA_MAX: cfg.smax <= cfg_data;
        ssdg_pkg::REG_SHARPEN_SIGMA_MIN: cfg.smin <= cfg_data;
        ssdg_pkg::REG_DEHALO_AMOUNT:     cfg.da   <= cfg_data[15:0];
        ssdg_pkg::REG_DEHALO_THRESHOLD:  cfg.dh   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_word     = '0;
    in_word.byp = (cfg.sa == 16'sd0) && (cfg.da == 16'd0);
    in_word.br  = bin_real;
    in_word.bi  = bin_imag;
    in_word.gr  = grid_real;
    in_word.gi  = grid_imag;
    in_word.ws  = sharpen_weight;
    in_word.wd  = dehalo_weight;
    in_word.f   = grid_fraction;
  end

  // a stage moves when it is empty or the stage after it moves
  assign en[NST-1] = !v[NST-1] || !res_stall;

  genvar k;
  generate
    for (k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= bin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pipe[0] <= in_word;
    end
  end

  generate
    for (k = 1; k < NST; k++) begin : g_st
      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= v[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          pipe[k] <= step(k, pipe[k-1], cfg);
        end
      end
    end
  endgenerate

  assign bin_stall = !en[0];
  assign res_valid = v[NST-1];
  assign out_real  = pipe[NST-1].outr;
  assign out_imag  = pipe[NST-1].outi;

  `SSDG_ASSERT_NXT(a_take_word, clk, rst, bin_valid && !bin_stall, v[0])
  `SSDG_ASSERT_IMP(a_ratio_range, clk, rst, v[ST_R],
                   pipe[ST_R].q1 <= ((FB + 1)'(1) << FB))
  `SSDG_ASSERT_IMP(a_root_range, clk, rst, v[ST_WV - 1],
                   pipe[ST_WV - 1].sres <= 35'd65536)
  `SSDG_ASSERT_IMP(a_dehalo_gain, clk, rst, v[ST_S],
                   pipe[ST_S].dg <= QB'(ssdg_pkg::ONE_Q12))

endmodule

FILE: test/spectral_sharpen_dehalo_gain_test.sv
// ----------------------------------------------------------------------------
// spectral_sharpen_dehalo_gain_test
// streams complex bins through the gain block under several register settings,
// with random idle gaps and output stalls, and checks each result word against
// a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
module spectral_sharpen_dehalo_gain_test;

  localparam int SB = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint unsigned M48 = (64'd1 << 48) - 1;

  typedef struct {
    logic signed [SB-1:0] br, bi, gr, gi;
    logic [15:0] ws, wd;
    logic signed [23:0] frac;
  } bin_word_t;

  typedef struct {
    logic signed [SB-1:0] re, im;
  } gain_out_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [ssdg_pkg::CFG_BITS-1:0] cfg_data = '0;
  logic bin_valid = 0;
  logic bin_stall;
  logic signed [SB-1:0] bin_real = '0, bin_imag = '0, grid_real = '0, grid_imag = '0;
  logic [15:0] sharpen_weight = '0, dehalo_weight = '0;
  logic signed [23:0] grid_fraction = '0;
  logic res_valid;
  logic res_stall = 0;
  logic signed [SB-1:0] out_real, out_imag;

  spectral_sharpen_dehalo_gain #(.SAMPLE_BITS(SB)) dut (.*);

  always #5 clk = ~clk;

  // shadow of the register file
  longint sh_amount = 0;
  longint unsigned sh_smax = 0, sh_smin = 0, dh_amount = 0, dh_thresh = 0;

  bin_word_t pending_bins[$];
  gain_out_t expected_outs[$];
  int errors = 0, bins_sent = 0, outs_checked = 0, settings_run = 0;
  int cycles = 0, send_gap = 0, stall_left = 0, calm_left = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(n * 2^k / d) below one, saturating at one
  function automatic longint unsigned ratio_div(longint unsigned n, longint unsigned d, int k);
    longint unsigned r, q;
    if (n >= d) return 64'd1 << k;
    r = n;
    q = 0;
    for (int i = 0; i < k; i++) begin
      q = q << 1;
      if (r >= d - r) begin
        r = r - (d - r);
        q = q | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic gain_out_t predict_gain(bin_word_t w);
    gain_out_t o;
    longint gcr, gci, cr, ci, sg, dg, g, prod;
    longint unsigned p, q1, q2, v, t, dw, den;
    if (sh_amount == 0 && dh_amount == 0) begin
      o.re = w.br;
      o.im = w.bi;
      return o;
    end
    gcr = round_shift(longint'(w.frac) * longint'(w.gr), 16);
    gci = round_shift(longint'(w.frac) * longint'(w.gi), 16);
    cr = clip(longint'(w.br) - gcr, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    ci = clip(longint'(w.bi) - gci, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    p = longint'(cr * cr) + longint'(ci * ci) + 1;
    sg = 4096;
    dg = 4096;
    if (sh_amount != 0) begin
      q1 = ratio_div(p, p + sh_smin, 30);
      q2 = ratio_div(sh_smax, p + sh_smax, 30);
      v = int_sqrt(((q1 * q2) >> 30) << 2);
      prod = sh_amount * longint'(longint'(w.ws) * v);
      sg = clip(4096 + round_shift(prod, 32), -32768, 32767);
    end
    if (dh_amount != 0) begin
      t = ratio_div(p, p + dh_thresh, 16);
      dw = (dh_amount * w.wd + 64'h8000) >> 16;
      den = (64'd1 << 28) + dw * t;
      dg = longint'(((64'd1 << 40) + den / 2) / den);
    end
    g = clip(round_shift(sg * dg, 12), -32768, 32767);
    o.re = SB'(clip(round_shift(cr * g, 12) + gcr,
                    -(64'sd1 <<< (SB-1)), (64'sd1 <<< (SB-1)) - 1));
    o.im = SB'(clip(round_shift(ci * g, 12) + gci,
                    -(64'sd1 <<< (SB-1)), (64'sd1 <<< (SB-1)) - 1));
    return o;
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = $urandom_range(20, 200);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, outs_checked);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      bin_valid <= 1'b0;
    end else begin
      if (bin_valid && !bin_stall) begin
        bin_word_t cur;
        cur.br = bin_real; cur.bi = bin_imag; cur.gr = grid_real; cur.gi = grid_imag;
        cur.ws = sharpen_weight; cur.wd = dehalo_weight; cur.frac = grid_fraction;
        expected_outs.push_back(predict_gain(cur));
        bins_sent++;
      end
      if (!bin_valid || !bin_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          bin_valid <= 1'b0;
        end else if (pending_bins.size() > 0) begin
          bin_word_t nx;
          nx = pending_bins.pop_front();
          bin_real <= nx.br; bin_imag <= nx.bi; grid_real <= nx.gr; grid_imag <= nx.gi;
          sharpen_weight <= nx.ws; dehalo_weight <= nx.wd; grid_fraction <= nx.frac;
          bin_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          bin_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_outs.size() == 0) begin
          report_mismatch("unexpected word re", out_real, 0);
        end else begin
          gain_out_t e;
          e = expected_outs.pop_front();
          if (out_real !== e.re) report_mismatch("out_real", out_real, e.re);
          if (out_imag !== e.im) report_mismatch("out_imag", out_imag, e.im);
        end
        outs_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(ssdg_pkg::reg_idx_t idx, longint unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[ssdg_pkg::CFG_BITS-1:0];
    case (idx)
      ssdg_pkg::REG_SHARPEN_AMOUNT:    sh_amount = longint'(signed'(val[15:0]));
      ssdg_pkg::REG_SHARPEN_SIGMA_MAX: sh_smax = val & M48;
      ssdg_pkg::REG_SHARPEN_SIGMA_MIN: sh_smin = val & M48;
      ssdg_pkg::REG_DEHALO_AMOUNT:     dh_amount = val & 64'hFFFF;
      ssdg_pkg::REG_DEHALO_THRESHOLD:  dh_thresh = val & M48;
      default: ;
    endcase
  endtask

  task automatic set_regs(longint unsigned sa, longint unsigned smx, longint unsigned smn,
                          longint unsigned da, longint unsigned dh);
    write_reg(ssdg_pkg::REG_SHARPEN_AMOUNT, sa);
    write_reg(ssdg_pkg::REG_SHARPEN_SIGMA_MAX, smx);
    write_reg(ssdg_pkg::REG_SHARPEN_SIGMA_MIN, smn);
    write_reg(ssdg_pkg::REG_DEHALO_AMOUNT, da);
    write_reg(ssdg_pkg::REG_DEHALO_THRESHOLD, dh);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bins.size() != 0 || expected_outs.size() != 0 || bin_valid);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      2: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
      default: return $signed(24'($urandom)) >>> $urandom_range(0, 20);
    endcase
  endfunction

  function automatic longint unsigned rand_power();
    longint unsigned v;
    v = {$urandom, $urandom};
    return (v & M48) >> $urandom_range(0, 47);
  endfunction

  task automatic queue_random(int n);
    bin_word_t w;
    repeat (n) begin
      w.br = rand_sample(); w.bi = rand_sample();
      w.gr = rand_sample(); w.gi = rand_sample();
      w.ws = 16'($urandom); w.wd = 16'($urandom);
      case ($urandom_range(0, 3))
        0: w.frac = '0;
        1: w.frac = 24'($urandom);
        default: w.frac = $signed(24'($urandom_range(0, 131072))) - 24'sd65536;
      endcase
      pending_bins.push_back(w);
    end
  endtask

  task automatic queue_bin(longint br, longint bi, longint gr, longint gi,
                           int ws, int wd, longint frac);
    bin_word_t w;
    w.br = SB'(br); w.bi = SB'(bi); w.gr = SB'(gr); w.gi = SB'(gi);
    w.ws = 16'(ws); w.wd = 16'(wd); w.frac = 24'(frac);
    pending_bins.push_back(w);
  endtask

  task automatic queue_directed();
    queue_bin(0, 0, 0, 0, 0, 0, 0);
    queue_bin(8388607, -8388608, 0, 0, 65535, 65535, 0);
    queue_bin(-8388608, 8388607, 8388607, -8388608, 65535, 0, 65536);
    // big grid times big fraction gives the largest residual the fields allow
    queue_bin(8388607, 8388607, -8388608, -8388608, 65535, 65535, 8388607);
    queue_bin(-8388608, -8388608, 8388607, 8388607, 65535, 65535, 8388607);
    queue_bin(-8388608, 8388607, 8388607, -8388608, 0, 65535, -8388608);
    queue_bin(1, -1, 0, 0, 65535, 65535, 0);
    queue_bin(100, 200, 50, -50, 32768, 32768, 32768);
    queue_bin(-1, 0, -1, -1, 1, 1, -1);
    queue_bin(4095, -4096, 1000, 1000, 65535, 65535, -65536);
    queue_bin(8388607, 8388607, 8388607, 8388607, 65535, 65535, 65536);
    queue_bin(0, 0, 8388607, -8388608, 65535, 65535, 8388607);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all amounts zero: plain pass-through
    queue_directed();
    queue_random(100);
    wait_drained();

    // sharpen on but no upper sigma: unit sharpen gain
    set_regs(16'h7FFF, 0, 0, 0, 0);
    queue_directed();
    queue_random(80);
    wait_drained();

    // strongest gains, to drive the gain into saturation
    set_regs(16'h7FFF, M48, 0, 16'hFFFF, 0);
    queue_directed();
    queue_random(120);
    wait_drained();

    set_regs(16'h8000, 1000000, M48, 16'h1000, M48);
    queue_directed();
    queue_random(120);
    wait_drained();

    set_regs(0, M48, M48, 16'hFFFF, 1);
    queue_random(100);
    wait_drained();

    repeat (6) begin
      set_regs($urandom_range(0, 65535), rand_power(), rand_power(),
               ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535), rand_power());
      queue_random(100);
      wait_drained();
    end

    $display("%0d bins checked over %0d register settings, %0d result words seen",
             bins_sent, settings_run + 1, outs_checked);
    if (errors == 0 && expected_outs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
